>>> rtl/mbq_pkg.sv
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared codes, types and helpers of the keyed mailbox queue engine.
// ----------------------------------------------------------------------------
package mbq_pkg;

  // Widest slot index that the directory result can carry (up to 64 slots).
  localparam int SLOT_IDX_MAX_W = 6;

  // Most bytes a single read can hand back (sixteen beats of eight bytes).
  localparam int RESULT_BYTES = 128;

  localparam logic [2:0] KIND_WBEGIN = 3'd0;
  localparam logic [2:0] KIND_WDATA  = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_PEEK   = 3'd3;
  localparam logic [2:0] KIND_FORGET = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_KEY = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_NO_OPEN = 3'd4;

  typedef struct packed {
    logic                      hit;
    logic [SLOT_IDX_MAX_W-1:0] hit_idx;
    logic                      free;
    logic [SLOT_IDX_MAX_W-1:0] free_idx;
  } dir_res_t;

  // Mask that keeps the low cnt bytes of a word; counts of eight or more keep all.
  function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (cnt > 4'(i)) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

>>> rtl/mbq_ram.sv
// ----------------------------------------------------------------------------
// mbq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/mbq_dir.sv
// ----------------------------------------------------------------------------
// mbq_dir
// Key directory: matches a key against the used slots and finds a free slot.
// ----------------------------------------------------------------------------
module mbq_dir #(
  parameter int QUEUE_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         key,
  input  logic                alloc,
  output mbq_pkg::dir_res_t   res
);
  import mbq_pkg::*;

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  logic [QUEUE_COUNT-1:0] used;
  logic [63:0]            keys [QUEUE_COUNT];

  always_comb begin
    res = '0;
    for (int i = QUEUE_COUNT - 1; i >= 0; i--) begin
      if (used[i] && keys[i] == key) begin
        res.hit     = 1'b1;
        res.hit_idx = SLOT_IDX_MAX_W'(i);
      end
      if (!used[i]) begin
        res.free     = 1'b1;
        res.free_idx = SLOT_IDX_MAX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (alloc) begin
      used[res.free_idx[QW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) keys[res.free_idx[QW-1:0]] <= key;
  end

endmodule

>>> rtl/named_mailbox_queue_engine_unit.sv
// ----------------------------------------------------------------------------
// named_mailbox_queue_engine_unit
// Keyed mailbox: a table of message rings named by 64-bit keys.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item with one result goes through accept,
// key lookup, execute and the result beat. An item that fails the key lookup
// or finds no open write, a peek of an unknown key, a forget and an unknown
// kind skip the execute step. A data word whose bytes straddle two stored
// words adds a spill step for the second write. For a read that returns a
// message, accept, lookup and execute are followed by the length memory read,
// and each result beat is then preceded by a word step, since every word comes
// out of the registered message memory; a zero-length read goes from the
// length read straight to its result beat.
// Messages live in a word memory of QUEUE_COUNT*RING_DEPTH*ceil(MESSAGE_BYTES/8)
// entries and lengths in a memory of QUEUE_COUNT*RING_DEPTH entries; neither
// needs clearing after reset.
module named_mailbox_queue_engine_unit #(
  parameter int QUEUE_COUNT   = 8,
  parameter int RING_DEPTH    = 16,
  parameter int MESSAGE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [63:0] queue_key,
  input  logic [7:0]  task_id,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  input  logic [7:0]  max_len,
  input  logic        after_wake,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [63:0] data_word_res,
  output logic [3:0]  byte_count_res,
  output logic        last,
  output logic [7:0]  total_len,
  output logic        ready_flag,
  output logic        parked,
  output logic        wake_valid,
  output logic [7:0]  wake_task
);
  import mbq_pkg::*;

  localparam int QW  = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int HW  = $clog2(RING_DEPTH);
  localparam int NE  = QUEUE_COUNT * RING_DEPTH;
  localparam int EW  = $clog2(NE);
  localparam int WPM = (MESSAGE_BYTES + 7) / 8;
  localparam int NW  = NE * WPM;
  localparam int AW  = $clog2(NW);
  localparam int BW  = $clog2(MESSAGE_BYTES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SPILL = 3'd3;
  localparam logic [2:0] S_LEN   = 3'd4;
  localparam logic [2:0] S_WORD  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    state;
  logic [2:0]    i_kind;
  logic [63:0]   i_key;
  logic [7:0]    i_task;
  logic [63:0]   i_data;
  logic [3:0]    i_bc;
  logic          i_last;
  logic [7:0]    i_maxl;
  logic          i_aw;
  logic [QW-1:0] cur;
  logic          write_open;
  logic [QW-1:0] write_slot;
  logic [BW-1:0] write_bytes;
  logic [63:0]   acc;
  logic [HW-1:0] head   [QUEUE_COUNT];
  logic [HW-1:0] tail   [QUEUE_COUNT];
  logic [7:0]    waiter [QUEUE_COUNT];
  logic [EW-1:0] rd_ent;
  logic [7:0]    rd_total;
  logic [3:0]    rk;
  logic          rd_more;
  logic [AW-1:0] spill_addr;
  logic [63:0]   spill_data;

  dir_res_t      dres;
  logic          key_zero;
  logic          found;
  logic          alloc;

  logic [HW-1:0] h, t, h_inc, t_inc;
  logic [7:0]    wt;
  logic [EW-1:0] ent_w, ent_r;
  logic [2:0]    off;
  logic [3:0]    bc_cap, nb;
  logic [BW-1:0] room, wb_next;
  logic [127:0]  merged;
  logic          spill;
  logic [AW-1:0] waddr_lo;
  logic [7:0]    len_store;

  logic          len_we, len_re, msg_we, msg_re;
  logic [AW-1:0] msg_waddr, msg_raddr;
  logic [63:0]   msg_wdata, msg_rdata;
  logic [7:0]    len_rdata;
  logic [7:0]    rd_n, rem;
  logic [3:0]    cnt;

  mbq_dir #(.QUEUE_COUNT(QUEUE_COUNT)) u_dir (
    .clk   (clk),
    .rst   (rst),
    .key   (i_key),
    .alloc (alloc),
    .res   (dres)
  );

  assign key_zero = (i_key == 64'd0);
  assign found    = dres.hit && !key_zero;
  assign alloc    = (state == S_LOOK) && (i_kind == KIND_WBEGIN || i_kind == KIND_READ) &&
                    !key_zero && !dres.hit && dres.free;

  assign h     = head[cur];
  assign t     = tail[cur];
  assign wt    = waiter[cur];
  assign h_inc = (32'(h) == RING_DEPTH - 1) ? '0 : h + 1'b1;
  assign t_inc = (32'(t) == RING_DEPTH - 1) ? '0 : t + 1'b1;
  assign ent_w = EW'(32'(cur) * RING_DEPTH + 32'(h));
  assign ent_r = EW'(32'(cur) * RING_DEPTH + 32'(t));

  // Bytes append at the running offset; the partial word is held in acc so
  // each stored word is always written whole.
  assign off     = write_bytes[2:0];
  assign bc_cap  = (i_bc > 4'd8) ? 4'd8 : i_bc;
  assign room    = BW'(MESSAGE_BYTES) - write_bytes;
  assign nb      = (32'(room) < 32'(bc_cap)) ? 4'(room) : bc_cap;
  assign wb_next = write_bytes + BW'(nb);
  assign merged  = {64'd0, acc & byte_mask({1'b0, off})} |
                   ({64'd0, i_data & byte_mask(nb)} << {off, 3'b000});
  assign spill   = ({1'b0, off} + nb) > 4'd8;
  assign waddr_lo  = AW'(32'(ent_w) * WPM + 32'(write_bytes >> 3));
  assign len_store = (32'(wb_next) > RESULT_BYTES) ? 8'(RESULT_BYTES) : 8'(wb_next);

  assign rd_n = (len_rdata > i_maxl) ? i_maxl : len_rdata;
  assign rem  = rd_total - {1'b0, rk, 3'b000};
  assign cnt  = (rem >= 8'd8) ? 4'd8 : rem[3:0];

  always_comb begin
    msg_we    = 1'b0;
    msg_waddr = waddr_lo;
    msg_wdata = merged[63:0];
    if (state == S_EXEC && i_kind == KIND_WDATA && nb != 4'd0) begin
      msg_we = 1'b1;
    end else if (state == S_SPILL) begin
      msg_we    = 1'b1;
      msg_waddr = spill_addr;
      msg_wdata = spill_data;
    end
  end

  assign len_we = (state == S_EXEC) && (i_kind == KIND_WDATA) && i_last;
  assign len_re = (state == S_EXEC) && (i_kind == KIND_READ) && (h != t);

  always_comb begin
    msg_re    = 1'b0;
    msg_raddr = AW'(32'(rd_ent) * WPM);
    if (state == S_LEN) begin
      msg_re = 1'b1;
    end else if (state == S_OUT && out_ready && rd_more) begin
      msg_re    = 1'b1;
      msg_raddr = AW'(32'(rd_ent) * WPM + 32'(rk) + 1);
    end
  end

  mbq_ram #(.WIDTH(8), .DEPTH(NE)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (ent_w),
    .wdata (len_store),
    .re    (len_re),
    .raddr (ent_r),
    .rdata (len_rdata)
  );

  mbq_ram #(.WIDTH(64), .DEPTH(NW)) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (msg_wdata),
    .re    (msg_re),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_open  <= 1'b0;
      write_slot  <= '0;
      write_bytes <= '0;
      rd_more     <= 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head[i]   <= '0;
        tail[i]   <= '0;
        waiter[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            i_kind <= kind;
            i_key  <= queue_key;
            i_task <= task_id;
            i_data <= data_word;
            i_bc   <= byte_count;
            i_last <= last_word;
            i_maxl <= max_len;
            i_aw   <= after_wake;
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          status         <= ST_OK;
          data_word_res  <= '0;
          byte_count_res <= '0;
          last           <= 1'b1;
          total_len      <= '0;
          ready_flag     <= 1'b0;
          parked         <= 1'b0;
          wake_valid     <= 1'b0;
          wake_task      <= '0;
          rd_more        <= 1'b0;
          state          <= S_OUT;
          case (i_kind)
            KIND_WBEGIN, KIND_READ: begin
              if (i_kind == KIND_WBEGIN) write_open <= 1'b0;
              if (found) begin
                cur   <= dres.hit_idx[QW-1:0];
                state <= S_EXEC;
              end else if (alloc) begin
                cur   <= dres.free_idx[QW-1:0];
                head[dres.free_idx[QW-1:0]]   <= '0;
                tail[dres.free_idx[QW-1:0]]   <= '0;
                waiter[dres.free_idx[QW-1:0]] <= '0;
                state <= S_EXEC;
              end else begin
                status <= ST_BAD_KEY;
              end
            end
            KIND_WDATA: begin
              if (write_open) begin
                cur   <= write_slot;
                state <= S_EXEC;
              end else begin
                status <= ST_NO_OPEN;
              end
            end
            KIND_PEEK: begin
              if (found) begin
                cur   <= dres.hit_idx[QW-1:0];
                state <= S_EXEC;
              end
            end
            KIND_FORGET: begin
              for (int i = 0; i < QUEUE_COUNT; i++) begin
                if (waiter[i] == i_task) waiter[i] <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        S_EXEC: begin
          state <= S_OUT;
          case (i_kind)
            KIND_WBEGIN: begin
              if (h_inc == t) begin
                status <= ST_FULL;
              end else begin
                write_open  <= 1'b1;
                write_slot  <= cur;
                write_bytes <= '0;
              end
            end
            KIND_WDATA: begin
              write_bytes <= wb_next;
              acc         <= ({1'b0, off} + nb >= 4'd8) ? merged[127:64] : merged[63:0];
              spill_addr  <= waddr_lo + 1'b1;
              spill_data  <= merged[127:64];
              if (spill) state <= S_SPILL;
              if (i_last) begin
                head[cur]  <= h_inc;
                write_open <= 1'b0;
                total_len  <= 8'(wb_next);
                if (wt != 8'd0) begin
                  wake_valid  <= 1'b1;
                  wake_task   <= wt;
                  waiter[cur] <= '0;
                end
              end
            end
            KIND_READ: begin
              if (i_aw) waiter[cur] <= '0;
              if (h == t) begin
                if (!i_aw) waiter[cur] <= i_task;
                status <= ST_EMPTY;
                parked <= !i_aw && (i_task != 8'd0);
              end else begin
                tail[cur] <= t_inc;
                rd_ent    <= ent_r;
                state     <= S_LEN;
              end
            end
            KIND_PEEK: begin
              ready_flag <= (h != t);
            end
            default: begin
            end
          endcase
        end
        S_SPILL: begin
          state <= S_OUT;
        end
        S_LEN: begin
          rd_total <= rd_n;
          rk       <= '0;
          if (rd_n == 8'd0) begin
            state <= S_OUT;
          end else begin
            state <= S_WORD;
          end
        end
        S_WORD: begin
          data_word_res  <= msg_rdata & byte_mask(cnt);
          byte_count_res <= cnt;
          last           <= (rem <= 8'd8);
          rd_more        <= (rem > 8'd8);
          total_len      <= rd_total;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (rd_more) begin
              rk    <= rk + 1'b1;
              state <= S_WORD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The two sides of the block are never open at the same time.
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output both open");

  // A word fetch only happens while bytes of the message remain.
  a_word_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WORD) |-> ({1'b0, rk, 3'b000} < {1'b0, rd_total}))
    else $error("read word past message end");

  // After an accepted beat the block always goes to the key lookup.
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_LOOK))
    else $error("accepted beat not looked up");

endmodule
